>>> hdl/sorted_wait_queue_with_service_slots_unit_assert.svh
// ---------------------------------------------------------------------------
// sorted wait queue assertion macros
// clocked implication checks shared by the queue rtl
// ---------------------------------------------------------------------------
`ifndef SORTED_WAIT_QUEUE_WITH_SERVICE_SLOTS_UNIT_ASSERT_SVH
`define SORTED_WAIT_QUEUE_WITH_SERVICE_SLOTS_UNIT_ASSERT_SVH

// same-cycle implication
`define SWQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("queue check failed");

// next-cycle implication
`define SWQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("queue check failed");

`endif

>>> hdl/swq_pkg.sv
// ---------------------------------------------------------------------------
// swq_pkg
// types and codes of the sorted wait queue
// ---------------------------------------------------------------------------
`default_nettype none

package swq_pkg;

  localparam int KEY_W = 48;

  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_START  = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BADSLOT = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] cust_id;
    logic [15:0] arrival;
    logic [15:0] service_len;
    logic        slot;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] entry_id;
    logic        entry_slot;
    logic [8:0]  queue_len;
    logic [1:0]  busy_servers;
  } out_word_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic insert;
    logic remove;
    key_t key;
    logic slot;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> hdl/swq_cell.sv
// ---------------------------------------------------------------------------
// swq_cell
// one position of the sorted row: compare, hold, shift up or shift down
// ---------------------------------------------------------------------------
`default_nettype none

module swq_cell #(
  parameter int IDX = 0,
  parameter int CW  = 9
) (
  input  wire logic              clk,
  input  wire swq_pkg::cell_ctl_t ctl,
  input  wire logic [CW-1:0]     count,
  input  wire logic [1:0]        in_service,
  input  wire logic              left_take,
  input  wire swq_pkg::key_t     left_entry,
  input  wire swq_pkg::key_t     right_entry,
  output logic                   take,
  output swq_pkg::key_t          entry
);

  logic at_or_above_count;
  logic waiting;
  logic shift_down;

  assign at_or_above_count = CW'(IDX) >= count;
  assign waiting           = CW'(IDX) >= CW'(in_service);
  // this cell sits at or after the insertion point
  assign take       = at_or_above_count || (waiting && (entry > ctl.key));
  assign shift_down = CW'(IDX) >= CW'(ctl.slot);

  always_ff @(posedge clk) begin
    if (ctl.insert && take) begin
      entry <= left_take ? left_entry : ctl.key;
    end else if (ctl.remove && shift_down) begin
      entry <= right_entry;
    end
  end

endmodule

`default_nettype wire

>>> hdl/sorted_wait_queue_with_service_slots_unit.sv
// ---------------------------------------------------------------------------
// sorted_wait_queue_with_service_slots_unit
// ordered wait list with protected service slots, built as a row of cells
// ---------------------------------------------------------------------------
// usage:
//   a command word is taken on item when start is high and busy is low.
//   insert places (arrival, service_len, cust_id) in ascending order among
//   the waiting entries; start hands the first waiter to the next server
//   slot; finish removes the entry in the given slot and closes the gap.
//   exactly one result word follows each command on result, marked by a
//   single-cycle done strobe; the receiver cannot hold it off.
// timing:
//   the command is registered, then every cell of the row compares and
//   shifts together; done rises in the cycle after the command is registered,
//   with the result word registered on the same edge. busy is high while the
//   registered command is processed, so no new command is taken before it is done.
// reset:
//   rst clears the fill count, the servers in use and the pending strobe.
//   cell contents are not cleared; only occupied cells are ever read.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sorted_wait_queue_with_service_slots_unit_assert.svh"

module sorted_wait_queue_with_service_slots_unit #(
  parameter int DEPTH   = 256,
  parameter int SERVERS = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire swq_pkg::in_word_t item,
  output logic                   busy,
  output logic                   done,
  output swq_pkg::out_word_t     result
);

  localparam int CW = $clog2(DEPTH + 1);

  logic                op_valid;
  swq_pkg::in_word_t   op;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [1:0]          in_service;
  logic [1:0]          in_service_next;
  swq_pkg::out_word_t  res_next;
  swq_pkg::cell_ctl_t  ctl;
  logic [31:0]         count_wide;

  logic                cell_take  [DEPTH];
  swq_pkg::key_t       cell_entry [DEPTH];

  assign busy = op_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else begin
      op_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op <= item;
    end
  end

  assign count_wide = 32'(count_next);

  always_comb begin
    count_next      = count;
    in_service_next = in_service;
    ctl.insert      = 1'b0;
    ctl.remove      = 1'b0;
    ctl.key         = {op.arrival, op.service_len, op.cust_id};
    ctl.slot        = op.slot;
    res_next.status     = swq_pkg::ST_OK;
    res_next.entry_id   = '0;
    res_next.entry_slot = 1'b0;
    if (op_valid) begin
      unique case (op.cmd)
        swq_pkg::CMD_INSERT: begin
          if (count == CW'(DEPTH)) begin
            res_next.status = swq_pkg::ST_FULL;
          end else begin
            ctl.insert = 1'b1;
            count_next = count + CW'(1);
          end
        end
        swq_pkg::CMD_START: begin
          if (in_service >= 2'(SERVERS) || count <= CW'(in_service)) begin
            res_next.status = swq_pkg::ST_EMPTY;
          end else begin
            for (int s = 0; s < SERVERS; s++) begin
              if (in_service == 2'(s)) begin
                res_next.entry_id = cell_entry[s][15:0];
              end
            end
            res_next.entry_slot = in_service[0];
            in_service_next     = in_service + 2'd1;
          end
        end
        swq_pkg::CMD_FINISH: begin
          if (2'(op.slot) >= in_service) begin
            res_next.status = swq_pkg::ST_BADSLOT;
          end else begin
            res_next.entry_id = op.slot ? cell_entry[1][15:0] : cell_entry[0][15:0];
            ctl.remove        = 1'b1;
            count_next        = count - CW'(1);
            in_service_next   = in_service - 2'd1;
          end
        end
        default: begin
        end
      endcase
    end
    res_next.queue_len    = count_wide[8:0];
    res_next.busy_servers = in_service_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      in_service <= '0;
      done       <= 1'b0;
    end else begin
      count      <= count_next;
      in_service <= in_service_next;
      done       <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid) begin
      result <= res_next;
    end
  end

  // row of cells, each word moves one place per update
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic          lt;
    swq_pkg::key_t le;
    swq_pkg::key_t re;
    if (i == 0) begin : g_first
      assign lt = 1'b0;
      assign le = ctl.key;
    end else begin : g_mid
      assign lt = cell_take[i-1];
      assign le = cell_entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign re = cell_entry[i];
    end else begin : g_inner
      assign re = cell_entry[i+1];
    end
    swq_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .count       (count),
      .in_service  (in_service),
      .left_take   (lt),
      .left_entry  (le),
      .right_entry (re),
      .take        (cell_take[i]),
      .entry       (cell_entry[i])
    );
  end

  `SWQ_ASSERT_NOW(a_serv_within_count, clk, rst, 1'b1, CW'(in_service) <= count)
  `SWQ_ASSERT_NOW(a_serv_within_slots, clk, rst, 1'b1, in_service <= 2'(SERVERS))
  `SWQ_ASSERT_NEXT(a_op_gives_word, clk, rst, op_valid, done && !busy)
  `SWQ_ASSERT_NEXT(a_accept_sets_busy, clk, rst, start && !busy, busy && !done)

endmodule

`default_nettype wire
